[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/ra32w_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ra32w_pkg
// Shared constants and types for the rolling Adler-32 window block.
// ----------------------------------------------------------------------------
package ra32w_pkg;

  localparam int MAX_WINDOW = 4096;
  localparam int PTR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WSIZE_W    = 13;
  localparam int DATA_W     = 8;
  localparam int SUM_W      = 16;
  localparam int QDEPTH     = 2;

  localparam logic [SUM_W-1:0] ADLER_MOD = 16'd65521;

  localparam int          ADDR_W          = 3;
  localparam logic [0:0]  REG_WINDOW_SIZE = 1'b0;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic [DATA_W-1:0] old_byte;
    logic              remove;
    logic              full;
    logic [SUM_W-1:0]  term;
  } ra32w_entry_t;

  typedef struct packed {
    logic               restart;
    logic [WSIZE_W-1:0] window_size;
  } ra32w_cfg_t;

endpackage
`default_nettype wire

[hdl/rolling_adler32_window.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_adler32_window
// Rolling Adler-32 over a byte stream with an optional sliding window.
// ----------------------------------------------------------------------------
// One byte per beat in, one checksum beat out per byte, sustained at one beat
// per cycle unless the receiver holds m_tready low. A beat goes through the
// window RAM read of the byte leaving the ring, then the queue, then the sum
// update register. Writing window_size restarts the checksum and empties the
// window; write it only while no beats are in flight. Sizes above 4096 act
// as 4096, zero gives plain Adler-32.
module rolling_adler32_window
  import ra32w_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // [7:0] data_byte
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [31:0]            m_tdata,   // [31:0] checksum
  output logic [0:0]             m_tuser,   // [0] window_full
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [WSIZE_W-1:0] window_size;
  ra32w_cfg_t         cfg;
  logic               reg_hit;
  logic               q_in_valid;
  logic               q_in_ready;
  ra32w_entry_t       q_in_entry;
  logic               q_out_valid;
  logic               q_out_ready;
  ra32w_entry_t       q_out_entry;
  logic               full_flag;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_WINDOW_SIZE);
  assign prdata  = reg_hit ? 32'(window_size) : '0;

  always_comb begin
    cfg.restart     = psel && penable && pwrite && pready && reg_hit;
    cfg.window_size = pwdata[WSIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= '0;
    end else if (cfg.restart) begin
      window_size <= cfg.window_size;
    end
  end

  ra32w_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .q_valid  (q_in_valid),
    .q_ready  (q_in_ready),
    .q_entry  (q_in_entry)
  );

  ra32w_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_entry (q_in_entry),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_entry  (q_out_entry)
  );

  ra32w_back u_back (
    .clk          (clk),
    .rst          (rst),
    .restart      (cfg.restart),
    .q_valid      (q_out_valid),
    .q_ready      (q_out_ready),
    .q_entry      (q_out_entry),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_checksum (m_tdata),
    .out_full     (full_flag)
  );

  assign m_tuser = full_flag;

endmodule
`default_nettype wire

[hdl/ra32w_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ra32w_ram
// Simple dual-port RAM, registered read with enable, read-before-write.
// ----------------------------------------------------------------------------
module ra32w_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
`default_nettype wire

[hdl/ra32w_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ra32w_front
// Accepts bytes, tracks ring position and fill, fetches the byte leaving the
// window and forms its reduced removal term.
// ----------------------------------------------------------------------------
module ra32w_front
  import ra32w_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ra32w_cfg_t         cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [DATA_W-1:0]  in_byte,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output ra32w_entry_t            q_entry
);

  `include "assert_macros.svh"

  localparam int PROD_W = WSIZE_W + DATA_W;

  logic [WSIZE_W-1:0] size_act;
  logic [PTR_W-1:0]   ring_pointer;
  logic [WSIZE_W-1:0] fill_count;

  logic               s1_valid;
  logic [DATA_W-1:0]  s1_byte;
  logic               s1_remove;
  logic               s1_full;

  logic [PTR_W-1:0]   ring_pointer_next;
  logic [WSIZE_W-1:0] fill_count_next;
  logic [PTR_W:0]     ptr_inc;
  logic               accept;
  logic               active;
  logic               remove;
  logic [DATA_W-1:0]  old_byte;
  logic [PROD_W-1:0]  prod;
  logic [16:0]        folded;
  logic [SUM_W-1:0]   term;
  logic [WSIZE_W-1:0] new_size;

  assign in_ready = !s1_valid || q_ready;
  assign accept   = in_valid && in_ready;
  assign active   = (size_act != '0);
  assign remove   = active && (fill_count >= size_act);
  assign ptr_inc  = {1'b0, ring_pointer} + 1'b1;

  always_comb begin
    ring_pointer_next = ring_pointer;
    fill_count_next   = fill_count;
    if (active) begin
      if (32'(ptr_inc) >= 32'(size_act)) begin
        ring_pointer_next = '0;
      end else begin
        ring_pointer_next = ptr_inc[PTR_W-1:0];
      end
      if (fill_count < size_act) begin
        fill_count_next = fill_count + 1'b1;
      end
    end
  end

  assign new_size = (32'(cfg.window_size) > MAX_WINDOW) ? WSIZE_W'(MAX_WINDOW)
                                                        : cfg.window_size;

  ra32w_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (accept && active),
    .waddr (ring_pointer),
    .wdata (in_byte),
    .re    (accept),
    .raddr (ring_pointer),
    .rdata (old_byte)
  );

  // 65536 folds to 15 modulo 65521, so one subtract finishes the reduction
  assign prod   = PROD_W'(size_act) * PROD_W'(old_byte) + 1'b1;
  assign folded = 17'(prod[PROD_W-1:16]) * 17'd15 + 17'(prod[15:0]);
  assign term   = (folded >= 17'(ADLER_MOD)) ? SUM_W'(folded - 17'(ADLER_MOD))
                                             : folded[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      size_act     <= '0;
      ring_pointer <= '0;
      fill_count   <= '0;
      s1_valid     <= 1'b0;
    end else if (cfg.restart) begin
      size_act     <= new_size;
      ring_pointer <= '0;
      fill_count   <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (accept) begin
        ring_pointer <= ring_pointer_next;
        fill_count   <= fill_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte   <= in_byte;
      s1_remove <= remove;
      s1_full   <= active && (fill_count_next >= size_act);
    end
  end

  assign q_valid = s1_valid;
  always_comb begin
    q_entry.data_byte = s1_byte;
    q_entry.old_byte  = old_byte;
    q_entry.remove    = s1_remove;
    q_entry.full      = s1_full;
    q_entry.term      = term;
  end

  `ASSERT_IMPLIES(a_ptr_range, active, 32'(ring_pointer) < 32'(size_act), "ring pointer past window")
  `ASSERT_ALWAYS(a_fill_range, fill_count <= size_act, "fill count past window")

endmodule
`default_nettype wire

[hdl/ra32w_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ra32w_queue
// Short FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module ra32w_queue
  import ra32w_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire ra32w_entry_t push_entry,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output ra32w_entry_t      pop_entry
);

  `include "assert_macros.svh"

  localparam int IDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  ra32w_entry_t     slots [QDEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (32'(count) < QDEPTH);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QDEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QDEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  `ASSERT_ALWAYS(a_count_range, 32'(count) <= QDEPTH, "queue count past depth")

endmodule
`default_nettype wire

[hdl/ra32w_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ra32w_back
// Applies removal and addition to sums A and B and holds the output beat.
// ----------------------------------------------------------------------------
module ra32w_back
  import ra32w_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         restart,
  input  wire logic         q_valid,
  output logic              q_ready,
  input  wire ra32w_entry_t q_entry,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [31:0]       out_checksum,
  output logic              out_full
);

  `include "assert_macros.svh"

  function automatic logic [SUM_W-1:0] sub_mod(input logic [SUM_W-1:0] x,
                                               input logic [SUM_W-1:0] y);
    logic [SUM_W:0] d;
    d = {1'b0, x} - {1'b0, y};
    return d[SUM_W] ? (d[SUM_W-1:0] + ADLER_MOD) : d[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] add_mod(input logic [SUM_W-1:0] x,
                                               input logic [SUM_W-1:0] y);
    logic [SUM_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s >= {1'b0, ADLER_MOD}) ? SUM_W'(s - {1'b0, ADLER_MOD}) : s[SUM_W-1:0];
  endfunction

  logic [SUM_W-1:0] sum_a;
  logic [SUM_W-1:0] sum_b;
  logic [SUM_W-1:0] sum_a_next;
  logic [SUM_W-1:0] sum_b_next;
  logic [SUM_W-1:0] a_trim;
  logic [SUM_W-1:0] b_trim;
  logic             pop;

  assign q_ready = !out_valid || out_ready;
  assign pop     = q_valid && q_ready;

  assign a_trim     = q_entry.remove ? sub_mod(sum_a, SUM_W'(q_entry.old_byte)) : sum_a;
  assign b_trim     = q_entry.remove ? sub_mod(sum_b, q_entry.term) : sum_b;
  assign sum_a_next = add_mod(a_trim, SUM_W'(q_entry.data_byte));
  assign sum_b_next = add_mod(b_trim, sum_a_next);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      sum_a     <= SUM_W'(1);
      sum_b     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_ready) begin
        out_valid <= q_valid;
      end
      if (pop) begin
        sum_a <= sum_a_next;
        sum_b <= sum_b_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_checksum <= {sum_b_next, sum_a_next};
      out_full     <= q_entry.full;
    end
  end

  `ASSERT_ALWAYS(a_sums_range, (sum_a < ADLER_MOD) && (sum_b < ADLER_MOD), "sum out of range")

endmodule
`default_nettype wire

[tb/sv/checksum_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksum_checker
// Watches the byte stream, the checksum stream and register writes of the
// rolling Adler-32 block. Keeps its own copy of the sums and the window
// ring, queues the checksum due for every accepted byte and compares each
// returned beat against the oldest one. Failures are counted for the top.
// ----------------------------------------------------------------------------
module checksum_checker
  import ra32w_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] data_byte
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [31:0]       m_tdata,   // [31:0] checksum
  input  logic [0:0]        m_tuser,   // [0] window_full
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              wrap_up,
  output int                fail_count
);

  localparam logic [ADDR_W-1:0] WSIZE_ADDR   = ADDR_W'(4 * REG_WINDOW_SIZE);
  localparam int unsigned       MODULUS      = ADLER_MOD;
  localparam int                REPORT_LINES = 30;

  typedef struct packed {
    logic [31:0] checksum;
    logic        window_full;
  } checksum_beat_t;

  checksum_beat_t     pending_sums[$];
  logic [7:0]         ring_copy [MAX_WINDOW];
  int unsigned        next_slot;
  int unsigned        held;
  int unsigned        sum_a;
  int unsigned        sum_b;
  logic [WSIZE_W-1:0] span;

  initial fail_count = 0;

  task automatic report_mismatch(input string msg);
    if (fail_count < REPORT_LINES) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    fail_count++;
  endtask

  function automatic void restart_sums();
    next_slot = 0;
    held      = 0;
    sum_a     = 1;
    sum_b     = 0;
  endfunction

  function automatic checksum_beat_t adler_advance(input logic [7:0] b);
    checksum_beat_t beat;
    int unsigned    size;
    int unsigned    old;
    int unsigned    term;
    size = (span > MAX_WINDOW) ? MAX_WINDOW : span;
    beat.window_full = 1'b0;
    if (size > 0) begin
      // oldest byte leaves before the new one goes in
      if (held >= size) begin
        old   = ring_copy[next_slot];
        term  = (1 + size * old) % MODULUS;
        sum_a = (sum_a >= old) ? sum_a - old : sum_a + MODULUS - old;
        sum_b = (sum_b >= term) ? sum_b - term : sum_b + MODULUS - term;
      end
      ring_copy[next_slot] = b;
      next_slot = (next_slot + 1 >= size) ? 0 : next_slot + 1;
      if (held < size) begin
        held++;
      end
      beat.window_full = (held >= size);
    end
    sum_a = sum_a + b;
    if (sum_a >= MODULUS) begin
      sum_a = sum_a - MODULUS;
    end
    sum_b = sum_b + sum_a;
    if (sum_b >= MODULUS) begin
      sum_b = sum_b - MODULUS;
    end
    beat.checksum = {sum_b[15:0], sum_a[15:0]};
    return beat;
  endfunction

  always @(posedge clk) begin : watch
    checksum_beat_t want;
    if (rst) begin
      span = '0;
      restart_sums();
      pending_sums.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_sums.size() == 0) begin
          report_mismatch($sformatf("checksum beat %08h with nothing expected", m_tdata));
        end else begin
          want = pending_sums.pop_front();
          if (m_tdata !== want.checksum) begin
            report_mismatch($sformatf("checksum %08h, expected %08h", m_tdata, want.checksum));
          end
          if (m_tuser[0] !== want.window_full) begin
            report_mismatch($sformatf("window_full %b, expected %b",
                                      m_tuser[0], want.window_full));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        pending_sums.push_back(adler_advance(s_tdata));
      end
      if (psel && penable && pwrite && pready && paddr == WSIZE_ADDR) begin
        span = pwdata[WSIZE_W-1:0];
        restart_sums();
      end
      if (wrap_up) begin
        while (pending_sums.size() > 0) begin
          want = pending_sums.pop_front();
          report_mismatch($sformatf("checksum %08h never returned", want.checksum));
        end
      end
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams bytes into the rolling Adler-32 block under a range of window
// sizes: plain Adler-32, tiny windows, a window wide enough to need the
// removal term reduced, and 4096-byte and oversized windows. Both sides idle
// at random; the receiver also holds off for long stretches so the block
// backs up. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import ra32w_pkg::*;

  localparam logic [ADDR_W-1:0] WSIZE_ADDR    = ADDR_W'(4 * REG_WINDOW_SIZE);
  localparam logic [ADDR_W-1:0] SPARE_ADDR    = ADDR_W'(4);
  localparam int                SETTLE_CYCLES = 6;
  localparam int                LONG_HOLD     = 300;
  localparam int                HOLD_POINT_A  = 500;
  localparam int                HOLD_POINT_B  = 1100;
  localparam int                STALL_LIMIT   = 2000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [31:0]       m_tdata;
  logic [0:0]        m_tuser;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              wrap_up;
  int                fail_count;

  int unsigned tx_count   = 0;
  int unsigned rx_count   = 0;
  int unsigned full_beats = 0;
  int unsigned settings   = 0;
  int unsigned quiet      = 0;
  bit          tx_calm    = 1'b0;
  bit          rx_calm    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rolling_adler32_window i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  checksum_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .wrap_up    (wrap_up),
    .fail_count (fail_count)
  );

  // receiver: random back-pressure, plus two long hold-offs
  initial begin : sink
    int unsigned pause;
    m_tready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      pause = rx_calm ? 0 : $urandom_range(0, 10);
      if (rx_count == HOLD_POINT_A || rx_count == HOLD_POINT_B) begin
        pause = LONG_HOLD;
      end
      if (pause > 0) begin
        m_tready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      rx_count++;
      if (m_tuser[0]) begin
        full_beats++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    tx_count++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (rx_count != tx_count) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure_window(input int unsigned size);
    logic [31:0] word;
    settle();
    word = $urandom();
    word[WSIZE_W-1:0] = size[WSIZE_W-1:0];
    apb_write(WSIZE_ADDR, word);
    settings++;
  endtask

  function automatic logic [7:0] draw_byte(input bit heavy);
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (heavy && pick < 4) begin
      return 8'hFF;
    end
    case (pick)
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_phase(input int unsigned size, input int unsigned n, input bit heavy);
    configure_window(size);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      send_byte(draw_byte(heavy));
    end
  endtask

  initial begin : stimulus
    int unsigned counted;
    int unsigned size;
    int unsigned n;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    wrap_up  = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // plain Adler-32 straight out of reset
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'hAA);
    send_byte(8'h55);
    // write to an unmapped register: sums must carry on
    settle();
    apb_write(SPARE_ADDR, 32'hFFFF_FFFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    configure_window(1);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h01);
    configure_window(2);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    configure_window(0);
    send_byte(8'h12);

    run_phase(0, 350, 1'b1);
    run_phase(300, 400, 1'b0);
    run_phase(4097, 40, 1'b0);
    // oversized: acts as a 4096-byte window
    run_phase(8191, 200, 1'b0);
    counted = 1009;
    while (counted < 1290) begin
      size = $urandom_range(1, 40);
      n    = $urandom_range(20, 90);
      run_phase(size, n, 1'b0);
      counted += n;
    end
    run_phase(4096, 40, 1'b0);

    settle();
    wrap_up <= 1'b1;
    @(posedge clk);
    wrap_up <= 1'b0;
    @(posedge clk);
    $display("Streamed %0d bytes through %0d window settings, from plain Adler-32 to oversized.",
             tx_count, settings);
    $display("%0d checksum beats had the window full; receiver held off twice for %0d cycles.",
             full_beats, LONG_HOLD);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
